### hw/rtl/hdb_pkg.sv
package hdb_pkg;

  // Longest hole run before it closes, and the widest hole run that can be pending.
  localparam int ROW_LEN = 64;
  localparam int DISP_W  = 16;
  localparam int CNT_W   = $clog2(ROW_LEN + 1);

  // Run queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef logic signed [DISP_W-1:0] disp_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MIN_DISP = 1'b0,
    CFG_MAX_DISP = 1'b1
  } cfg_idx_t;

  localparam disp_t MIN_DISP_RST = 16'sd0;
  localparam disp_t MAX_DISP_RST = 16'sd16384;

  // One closed run: a number of holes sharing one range, optionally
  // followed by the known sample that closed it.
  typedef struct packed {
    logic [CNT_W-1:0] hole_count;
    disp_t            low;
    disp_t            high;
    logic             hole_done;
    logic             has_known;
    logic             known_done;
  } run_cmd_t;

endpackage

### hw/rtl/hdb_front.sv
module hdb_front import hdb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          is_known,
  input  disp_t         disparity,
  input  logic          end_of_row,
  input  logic          q_full,
  output logic          push,
  output run_cmd_t      push_cmd
);

  disp_t            min_disparity;
  disp_t            max_disparity;
  logic             left_known;
  disp_t            left_value;
  logic [CNT_W-1:0] pending;

  logic             accept;
  logic [CNT_W-1:0] pending_inc;
  logic             close_hole;
  disp_t            lo;
  disp_t            hi;

  assign cfg_ready   = 1'b1;
  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign pending_inc = pending + CNT_W'(1);
  assign close_hole  = !is_known && (end_of_row || (pending_inc >= CNT_W'(ROW_LEN)));
  assign push        = accept && (is_known || close_hole);

  // Range of the run from the left neighbor and, for a known sample, the right one.
  always_comb begin
    priority if (left_known && is_known) begin
      lo = (left_value < disparity) ? left_value : disparity;
      hi = (left_value < disparity) ? disparity : left_value;
    end else if (left_known) begin
      lo = min_disparity;
      hi = left_value;
    end else if (is_known) begin
      lo = min_disparity;
      hi = disparity;
    end else begin
      lo = min_disparity;
      hi = max_disparity;
    end
  end

  always_comb begin
    push_cmd.hole_count = is_known ? pending : pending_inc;
    push_cmd.low        = lo;
    push_cmd.high       = hi;
    push_cmd.hole_done  = !is_known;
    push_cmd.has_known  = is_known;
    push_cmd.known_done = is_known && end_of_row;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_disparity <= MIN_DISP_RST;
      max_disparity <= MAX_DISP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_DISP: min_disparity <= disp_t'(cfg_data);
        CFG_MAX_DISP: max_disparity <= disp_t'(cfg_data);
      endcase
    end
  end

  // Row state: last known sample and the open hole run.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_known <= 1'b0;
      left_value <= '0;
      pending    <= '0;
    end else if (accept) begin
      if (is_known) begin
        pending    <= '0;
        left_known <= !end_of_row;
        left_value <= end_of_row ? disp_t'(0) : disparity;
      end else if (close_hole) begin
        pending    <= '0;
        left_known <= 1'b0;
        left_value <= '0;
      end else begin
        pending <= pending_inc;
      end
    end
  end

endmodule

### hw/rtl/hdb_queue.sv
module hdb_queue import hdb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  run_cmd_t push_cmd,
  input  logic     pop,
  output run_cmd_t head,
  output logic     full,
  output logic     empty
);

  run_cmd_t          entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

### hw/rtl/hdb_back.sv
module hdb_back import hdb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  run_cmd_t head,
  input  logic     q_empty,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     is_hole,
  output disp_t    low_bound,
  output disp_t    high_bound,
  output logic     row_done
);

  logic [CNT_W-1:0] rem;
  disp_t            cur_low;
  disp_t            cur_high;
  logic             cur_hole_done;
  logic             cur_has_known;
  logic             cur_known_done;

  logic             cur_busy;
  logic             out_free;

  assign cur_busy = (rem != '0) || cur_has_known;
  assign out_free = !out_valid || out_ready;
  assign pop      = !cur_busy && !q_empty;

  // Load a run from the queue, then play its holes and the closing sample out.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem           <= '0;
      cur_has_known <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        if (out_ready) out_valid <= 1'b0;
        rem            <= head.hole_count;
        cur_low        <= head.low;
        cur_high       <= head.high;
        cur_hole_done  <= head.hole_done;
        cur_has_known  <= head.has_known;
        cur_known_done <= head.known_done;
      end else if (cur_busy && out_free) begin
        out_valid <= 1'b1;
        if (rem != '0) begin
          is_hole    <= 1'b1;
          low_bound  <= cur_low;
          high_bound <= cur_high;
          row_done   <= cur_hole_done && (rem == CNT_W'(1));
          rem        <= rem - CNT_W'(1);
        end else begin
          is_hole       <= 1'b0;
          low_bound     <= '0;
          high_bound    <= '0;
          row_done      <= cur_known_done;
          cur_has_known <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/hole_disparity_bounds.sv
// A known sample leaves through the run queue, the back end's run registers
// and the output register, after the held hole run ahead of it; holes leave
// only when their run closes. The block takes one request per cycle while the
// 4-entry run queue has room; the back end plays out one result per cycle
// within a run while out_ready holds. Reset (synchronous, active high) clears
// row state, queue and output valid and restores the range registers to 0 and 64.0.
module hole_disparity_bounds import hdb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_known,
  input  logic signed [15:0] disparity,
  input  logic        end_of_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_hole,
  output logic signed [15:0] low_bound,
  output logic signed [15:0] high_bound,
  output logic        row_done
);

  logic     push;
  run_cmd_t push_cmd;
  logic     pop;
  run_cmd_t head;
  logic     q_full;
  logic     q_empty;

  // Front end: row tracking and run closing.
  hdb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_known   (is_known),
    .disparity  (disparity),
    .end_of_row (end_of_row),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Closed runs waiting for the back end.
  hdb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: result emission.
  hdb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_hole    (is_hole),
    .low_bound  (low_bound),
    .high_bound (high_bound),
    .row_done   (row_done)
  );

endmodule

### hw/rtl/hdb_checker.sv
module hdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_hole,
  input logic [15:0] low_bound,
  input logic [15:0] high_bound,
  input logic        row_done
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_hole) && $stable(low_bound)
      && $stable(high_bound) && $stable(row_done))
    else $error("result changed while stalled");

  // A known sample carries no bounds.
  a_known_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_hole |-> low_bound == 16'd0 && high_bound == 16'd0)
    else $error("known sample carries bounds");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hole_disparity_bounds hdb_checker u_hdb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .is_hole    (is_hole),
  .low_bound  (low_bound),
  .high_bound (high_bound),
  .row_done   (row_done)
);

### bench/hole_bounds_check.sv
module hole_bounds_check import hdb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        is_known,
  input  disp_t       disparity,
  input  logic        end_of_row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        is_hole,
  input  disp_t       low_bound,
  input  disp_t       high_bound,
  input  logic        row_done,
  output int          outstanding,
  output int          failures
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result as it should leave the block.
  typedef struct packed {
    logic  hole;
    disp_t low;
    disp_t high;
    logic  done;
  } bounds_t;

  bounds_t     due_bounds[$];
  disp_t       range_min = MIN_DISP_RST;
  disp_t       range_max = MAX_DISP_RST;
  logic        left_seen = 1'b0;
  disp_t       left_disp = '0;
  int unsigned held_holes = 0;
  int          mismatches = 0;

  assign failures = mismatches;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] hdb check: %s", $realtime, msg);
  endtask

  // Queue a closed run of holes; all of them share the range built from the
  // left state and the optional right neighbor.
  function automatic void emit_hole_run(int unsigned count, logic right_seen, disp_t right_disp,
                                        logic last_done);
    disp_t   lo;
    disp_t   hi;
    bounds_t r;
    if (left_seen && right_seen) begin
      lo = (left_disp < right_disp) ? left_disp : right_disp;
      hi = (left_disp < right_disp) ? right_disp : left_disp;
    end else if (left_seen) begin
      lo = range_min;
      hi = left_disp;
    end else if (right_seen) begin
      lo = range_min;
      hi = right_disp;
    end else begin
      lo = range_min;
      hi = range_max;
    end
    for (int unsigned i = 0; i < count; i++) begin
      r.hole = 1'b1;
      r.low  = lo;
      r.high = hi;
      r.done = last_done && (i + 1 == count);
      due_bounds.insert(due_bounds.size(), r);
    end
  endfunction

  // Advance the row state by one accepted sample.
  function automatic void take_sample(logic known, disp_t d, logic eor);
    bounds_t r;
    if (known) begin
      emit_hole_run(held_holes, 1'b1, d, 1'b0);
      r.hole = 1'b0;
      r.low  = '0;
      r.high = '0;
      r.done = eor;
      due_bounds.insert(due_bounds.size(), r);
      held_holes = 0;
      left_seen  = !eor;
      left_disp  = eor ? disp_t'(0) : d;
    end else if (eor || held_holes + 1 >= ROW_LEN) begin
      // A row end or a run of ROW_LEN holes closes with no right neighbor.
      emit_hole_run(held_holes + 1, 1'b0, '0, 1'b1);
      held_holes = 0;
      left_seen  = 1'b0;
      left_disp  = '0;
    end else begin
      held_holes++;
    end
  endfunction

  task automatic check_result();
    bounds_t want;
    if (due_bounds.size() == 0) begin
      report_mismatch($sformatf("unexpected result is_hole %0d low %0d high %0d row_done %0d",
                                is_hole, low_bound, high_bound, row_done));
      return;
    end
    want = due_bounds.pop_front();
    if (is_hole !== want.hole)
      report_mismatch($sformatf("is_hole got %0d, want %0d", is_hole, want.hole));
    if (low_bound !== want.low)
      report_mismatch($sformatf("low_bound got %0d, want %0d", low_bound, want.low));
    if (high_bound !== want.high)
      report_mismatch($sformatf("high_bound got %0d, want %0d", high_bound, want.high));
    if (row_done !== want.done)
      report_mismatch($sformatf("row_done got %0d, want %0d", row_done, want.done));
  endtask

  // Results leave only after their request has passed the run queue, so a result at
  // this edge is compared before the sample accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      due_bounds.delete();
      range_min  = MIN_DISP_RST;
      range_max  = MAX_DISP_RST;
      left_seen  = 1'b0;
      left_disp  = '0;
      held_holes = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_DISP: range_min = disp_t'(cfg_data);
          CFG_MAX_DISP: range_max = disp_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_sample(is_known, disparity, end_of_row);
      end
    end
    outstanding <= due_bounds.size();
  end

endmodule

### bench/hole_disparity_bounds_tb.sv
module hole_disparity_bounds_tb import hdb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 78;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_MIN_DISP;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        is_known = 1'b0;
  disp_t       disparity = '0;
  logic        end_of_row = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_hole;
  disp_t       low_bound;
  disp_t       high_bound;
  logic        row_done;
  int          outstanding;
  int          failures;

  bit          no_gaps = 1'b0;
  int          idle_cycles = 0;
  int          sample_count = 0;

  hole_disparity_bounds uut (.*);
  hole_bounds_check check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("hole_disparity_bounds: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each result, none in gap-free stretches.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic disp_t draw_disparity();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return disp_t'($urandom_range(0, 64)) - 16'sd32;
      default: return disp_t'($urandom);
    endcase
  endfunction

  task automatic write_range(cfg_idx_t idx, disp_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Present one sample, then idle, or now and then hold off until every
  // expected result has come out.
  task automatic send_sample(logic known, disp_t d, logic eor);
    int gap;
    in_valid   <= 1'b1;
    is_known   <= known;
    disparity  <= d;
    end_of_row <= eor;
    do @(posedge clk); while (!in_ready);
    sample_count++;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 99) < 2) begin
      in_valid <= 1'b0;
      wait_results();
    end else if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Close the row, let the block go idle so the ranges can be rewritten.
  task automatic end_phase();
    send_sample(1'b1, draw_disparity(), 1'b1);
    in_valid <= 1'b0;
    wait_results();
    repeat (8) @(posedge clk);
  endtask

  // One random row: mostly short rows of mixed density, some long ones,
  // a few hole runs that reach the row length, and some rows left open.
  task automatic random_row();
    int   kind;
    int   len;
    int   density;
    logic eor_last;
    kind     = $urandom_range(0, 99);
    no_gaps  = ($urandom_range(0, 3) == 0);
    density  = $urandom_range(0, 100);
    eor_last = ($urandom_range(0, 9) != 0);
    if (kind < 4) begin
      if ($urandom_range(0, 1)) send_sample(1'b1, draw_disparity(), 1'b0);
      repeat ($urandom_range(ROW_LEN, ROW_LEN + 6)) send_sample(1'b0, draw_disparity(), 1'b0);
      send_sample(1'b1, draw_disparity(), 1'b1);
    end else if (kind < 7) begin
      // Longest run that a closing sample still ends.
      if ($urandom_range(0, 1)) send_sample(1'b1, draw_disparity(), 1'b0);
      repeat (ROW_LEN - 1) send_sample(1'b0, draw_disparity(), 1'b0);
      send_sample(1'($urandom_range(0, 1)), draw_disparity(), 1'b1);
    end else begin
      len = (kind < 85) ? $urandom_range(1, 12) : $urandom_range(13, ROW_LEN);
      for (int i = 0; i < len; i++) begin
        send_sample($urandom_range(0, 99) < density, draw_disparity(),
                    eor_last && (i == len - 1));
      end
    end
  endtask

  initial begin
    disp_t min_set[4];
    disp_t max_set[4];
    int    target;
    min_set = '{16'sh8000, 16'sh7FFF, disp_t'($urandom), 16'sd0};
    max_set = '{16'sh7FFF, 16'sh8000, disp_t'($urandom), 16'sd16384};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset ranges. Holes before the first known
    // sample, between two known extremes, and at the row end after one.
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b1, 16'sh8000, 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b1, 16'sh7FFF, 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b1);
    // A row of holes only.
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b1);
    // A known sample alone on its row.
    send_sample(1'b1, 16'sh0180, 1'b1);
    // Neighbors in falling order, and a known sample closing the row.
    send_sample(1'b1, 16'sd5, 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b0);
    send_sample(1'b1, -16'sd3, 1'b1);
    // The row end is left out, so the left neighbor carries on.
    send_sample(1'b1, 16'sh1234, 1'b0);
    send_sample(1'b0, draw_disparity(), 1'b1);
    // A single hole at the row end.
    send_sample(1'b0, draw_disparity(), 1'b1);
    end_phase();

    // Random phases: full extremes, minimum above maximum, random, reset values.
    for (int p = 0; p < 4; p++) begin
      write_range(CFG_MIN_DISP, min_set[p]);
      write_range(CFG_MAX_DISP, max_set[p]);
      target = sample_count + PHASE_ITEMS;
      while (sample_count < target) random_row();
      no_gaps = 1'b0;
      end_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("hole_disparity_bounds: match");
    end else begin
      $display("hole_disparity_bounds: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/hdb_pkg.sv
hw/rtl/hdb_front.sv
hw/rtl/hdb_queue.sv
hw/rtl/hdb_back.sv
hw/rtl/hole_disparity_bounds.sv
hw/rtl/hdb_checker.sv
bench/hole_bounds_check.sv
bench/hole_disparity_bounds_tb.sv
